### rtl/core/efr_pkg.sv
// Package for the escaped frame receiver: field widths, function and
// register codes, reset markers and the per-item status struct.
// No dependencies.
package efr_pkg;

  localparam int BYTE_W     = 8;
  localparam int READ_IDX_W = 7;
  localparam int LEN_W      = 8;
  localparam int CFG_IDX_W  = 2;

  // Item functions.
  localparam logic FUNC_BYTE = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_START  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_END    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE = 2'd2;

  localparam logic [BYTE_W-1:0] START_RST  = 8'd241;
  localparam logic [BYTE_W-1:0] END_RST    = 8'd242;
  localparam logic [BYTE_W-1:0] ESCAPE_RST = 8'd243;

  // Status of one item, apart from the read data.
  typedef struct packed {
    logic             frame_done;
    logic [LEN_W-1:0] frame_length;
    logic             frame_overflow;
    logic             in_frame;
  } efr_status_t;

endpackage

### rtl/core/efr_channels.sv
// Channel interfaces of the escaped frame receiver: input items, results
// and configuration writes. Depends on efr_pkg.
interface efr_in_if import efr_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  func;
  logic [BYTE_W-1:0]     byte_in;
  logic [READ_IDX_W-1:0] read_index;

  modport source(output valid, func, byte_in, read_index, input ready);
  modport sink(input valid, func, byte_in, read_index, output ready);
endinterface

interface efr_out_if import efr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              frame_done;
  logic [LEN_W-1:0]  frame_length;
  logic              frame_overflow;
  logic              in_frame;
  logic [BYTE_W-1:0] read_data;

  modport source(output valid, frame_done, frame_length, frame_overflow, in_frame,
                 read_data, input ready);
  modport sink(input valid, frame_done, frame_length, frame_overflow, in_frame,
               read_data, output ready);
endinterface

interface efr_cfg_if import efr_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [BYTE_W-1:0]    data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

### rtl/core/efr_store.sv
// Frame byte store: one write port and one read port, read data registered.
// Depends on efr_pkg.
module efr_store import efr_pkg::*; #(
  parameter int DEPTH = 128,
  parameter int AW    = 7
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  logic [BYTE_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [AW-1:0]     rd_addr,
  output logic [BYTE_W-1:0] rd_data
);

  logic [BYTE_W-1:0] mem [DEPTH];
  logic [BYTE_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // The read register holds its value until the next read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### rtl/core/efr_ctrl.sv
// Frame control for the escaped frame receiver: marker registers, frame
// state and the store write for each received byte. Depends on efr_pkg.
module efr_ctrl import efr_pkg::*; #(
  parameter int DEPTH = 128,
  parameter int AW    = 7,
  parameter int CW    = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [BYTE_W-1:0]    cfg_data,
  input  logic                 item_acc,
  input  logic                 func,
  input  logic [BYTE_W-1:0]    byte_in,
  output logic                 wr_en,
  output logic [AW-1:0]        wr_addr,
  output efr_status_t          status
);

  logic [BYTE_W-1:0] start_r, end_r, escape_r;
  logic [CW-1:0]     widx_r, widx_nxt;
  logic              open_r, open_nxt;
  logic              esc_r, esc_nxt;
  logic              ovf_r, ovf_nxt;

  logic          is_start, is_end, new_frame, do_store, full, done;
  logic [CW-1:0] base_idx, idx_after;
  logic          base_ovf, ovf_after;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r  <= START_RST;
      end_r    <= END_RST;
      escape_r <= ESCAPE_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_START:  start_r  <= cfg_data;
        CFG_END:    end_r    <= cfg_data;
        CFG_ESCAPE: escape_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    is_start  = (byte_in == start_r);
    is_end    = !is_start && (byte_in == end_r);
    // A start marker after an escape inside a frame is plain data.
    new_frame = is_start && !(open_r && esc_r);
    base_idx  = new_frame ? '0 : widx_r;
    base_ovf  = new_frame ? 1'b0 : ovf_r;
    do_store  = is_start || open_r;
    full      = 32'(base_idx) >= DEPTH;
    wr_en     = item_acc && (func == FUNC_BYTE) && do_store && !full;
    wr_addr   = base_idx[AW-1:0];
    idx_after = (do_store && !full) ? base_idx + CW'(1) : base_idx;
    ovf_after = base_ovf || (do_store && full);
    done      = is_end && open_r && !esc_r;

    widx_nxt = done ? '0 : idx_after;
    open_nxt = new_frame || (open_r && !done);
    esc_nxt  = (byte_in == escape_r) && !esc_r;
    ovf_nxt  = ovf_after;

    if (func == FUNC_BYTE) begin
      status.frame_done     = done;
      status.frame_length   = done ? LEN_W'(idx_after) : '0;
      status.frame_overflow = ovf_after;
      status.in_frame       = open_nxt;
    end else begin
      status.frame_done     = 1'b0;
      status.frame_length   = '0;
      status.frame_overflow = ovf_r;
      status.in_frame       = open_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      widx_r <= '0;
      open_r <= 1'b0;
      esc_r  <= 1'b0;
      ovf_r  <= 1'b0;
    end else if (item_acc && (func == FUNC_BYTE)) begin
      widx_r <= widx_nxt;
      open_r <= open_nxt;
      esc_r  <= esc_nxt;
      ovf_r  <= ovf_nxt;
    end
  end

endmodule

### rtl/core/escaped_frame_receiver.sv
// Escaped frame receiver: collects byte-stuffed frames into a byte store and
// reads stored bytes back. One item is taken every clock cycle unless the
// result side stalls; a result passes the first stage, with the registered
// read of the store, then the output register, so an item can enter while a
// finished result waits. The store is not cleared at reset, so only positions
// written since reset should be read. Depends on efr_pkg, the channel
// interfaces, efr_ctrl and efr_store.
module escaped_frame_receiver import efr_pkg::*; #(
  parameter int BUFFER_DEPTH = 128
) (
  input logic      clk,
  input logic      rst_n,
  efr_in_if.sink   in_ch,
  efr_out_if.source out_ch,
  efr_cfg_if.sink  cfg_ch
);

  localparam int AW = $clog2(BUFFER_DEPTH);
  localparam int CW = $clog2(BUFFER_DEPTH + 1);
  localparam int RW = (AW > READ_IDX_W) ? AW : READ_IDX_W;

  logic              item_acc, s1_adv;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [RW-1:0]     rd_ext;
  logic              rd_ok, rd_en;
  logic [BYTE_W-1:0] rd_data;
  efr_status_t       status;

  logic              s1_v_r;
  efr_status_t       s1_res_r;
  logic              s1_rd_r;
  logic              out_v_r;
  efr_status_t       out_res_r;
  logic [BYTE_W-1:0] out_rdata_r;

  assign cfg_ch.ready = 1'b1;

  assign s1_adv       = s1_v_r && (!out_v_r || out_ch.ready);
  assign in_ch.ready  = !s1_v_r || s1_adv;
  assign item_acc     = in_ch.valid && in_ch.ready;

  assign rd_ext = RW'(in_ch.read_index);
  assign rd_ok  = 32'(rd_ext) < BUFFER_DEPTH;
  assign rd_en  = item_acc && (in_ch.func == FUNC_READ) && rd_ok;

  efr_ctrl #(.DEPTH(BUFFER_DEPTH), .AW(AW), .CW(CW)) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_ch.valid && cfg_ch.ready),
    .cfg_idx  (cfg_ch.index),
    .cfg_data (cfg_ch.data),
    .item_acc (item_acc),
    .func     (in_ch.func),
    .byte_in  (in_ch.byte_in),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .status   (status)
  );

  efr_store #(.DEPTH(BUFFER_DEPTH), .AW(AW)) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (in_ch.byte_in),
    .rd_en   (rd_en),
    .rd_addr (rd_ext[AW-1:0]),
    .rd_data (rd_data)
  );

  // The read register only changes on a new read, which happens only when
  // the first stage empties, so its data stays put while that stage waits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_v_r <= item_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (item_acc) begin
      s1_res_r <= status;
      s1_rd_r  <= rd_en;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (!out_v_r || out_ch.ready) begin
      out_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_res_r   <= s1_res_r;
      out_rdata_r <= s1_rd_r ? rd_data : '0;
    end
  end

  assign out_ch.valid          = out_v_r;
  assign out_ch.frame_done     = out_res_r.frame_done;
  assign out_ch.frame_length   = out_res_r.frame_length;
  assign out_ch.frame_overflow = out_res_r.frame_overflow;
  assign out_ch.in_frame       = out_res_r.in_frame;
  assign out_ch.read_data      = out_rdata_r;

  a_done_closes: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.frame_done |-> !out_ch.in_frame)
    else $error("completed frame reported as still open");

  a_read_no_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.read_data != '0 |-> !out_ch.frame_done &&
    out_ch.frame_length == '0)
    else $error("read result carries frame completion");

  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && out_v_r && !out_ch.ready |-> !in_ch.ready)
    else $error("input taken while both stages are full");

  a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    !item_acc |-> !wr_en && !rd_en)
    else $error("store accessed without an accepted transaction");

endmodule

### tb/testbench.sv
// Self-checking testbench for escaped_frame_receiver: directed rows, then random framed
// traffic in several marker settings, checked against typed rows or a local predictor.
// Depends on efr_pkg, the channel interfaces in efr_channels.sv and the receiver RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import efr_pkg::*;

  localparam int DEPTH       = 128;
  localparam int PHASE_ITEMS = 120;
  localparam int NUM_PHASES  = 8;
  localparam int CYCLE_LIMIT = 200000;
  localparam int MAX_REPORTS = 10;

  // Index 3 has no register behind it; writing it must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  typedef struct packed {
    efr_status_t       status;
    logic [BYTE_W-1:0] read_data;
  } efr_result_t;

  typedef struct packed {
    logic                  func;
    logic [BYTE_W-1:0]     byte_v;
    logic [READ_IDX_W-1:0] idx;
    bit                    typed;
    logic                  done;
    logic [LEN_W-1:0]      len;
    logic                  ovf;
    logic                  inf;
    logic [BYTE_W-1:0]     rdata;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  efr_in_if  in_ch();
  efr_out_if out_ch();
  efr_cfg_if cfg_ch();

  escaped_frame_receiver #(.BUFFER_DEPTH(DEPTH)) DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source),
    .cfg_ch (cfg_ch.sink)
  );

  always #10 clk = ~clk;

  // Shadow of the receiver state.
  logic [BYTE_W-1:0] frame_mem [DEPTH];
  bit   [DEPTH-1:0]  written = '0;
  int                wr_ptr = 0;
  bit                frame_is_open = 1'b0;
  bit                esc_pending = 1'b0;
  bit                ovf_seen = 1'b0;
  logic [BYTE_W-1:0] mk_start = START_RST;
  logic [BYTE_W-1:0] mk_end = END_RST;
  logic [BYTE_W-1:0] mk_escape = ESCAPE_RST;

  efr_result_t expected_results [$];

  int items_sent = 0;
  int phase_items = 0;
  int frames_closed = 0;
  int overflow_frames = 0;
  int reads_done = 0;
  int results_seen = 0;
  int mismatches = 0;
  int cycle_count = 0;
  int in_idle_pct = 0;
  int out_stall_pct = 0;
  int stall_left = 0;

  function automatic void keep_byte(logic [BYTE_W-1:0] b);
    if (wr_ptr < DEPTH) begin
      frame_mem[wr_ptr] = b;
      written[wr_ptr] = 1'b1;
      wr_ptr++;
    end else begin
      ovf_seen = 1'b1;
    end
  endfunction

  function automatic void set_marker(logic [CFG_IDX_W-1:0] idx, logic [BYTE_W-1:0] v);
    case (idx)
      CFG_START: begin
        mk_start = v;
      end
      CFG_END: begin
        mk_end = v;
      end
      CFG_ESCAPE: begin
        mk_escape = v;
      end
      default: begin
      end
    endcase
  endfunction

  // Works out the result of one item and moves the shadow state on.
  function automatic efr_result_t predict_item(logic func, logic [BYTE_W-1:0] b,
                                               logic [READ_IDX_W-1:0] idx);
    efr_result_t r;
    r = '0;
    if (func == FUNC_READ) begin
      r.read_data = frame_mem[idx];
      reads_done++;
    end else begin
      // The start test takes precedence when markers share a value.
      if (b == mk_start) begin
        if (frame_is_open && esc_pending) begin
          keep_byte(b);
        end else begin
          wr_ptr = 0;
          ovf_seen = 1'b0;
          frame_is_open = 1'b1;
          keep_byte(b);
        end
      end else if (b == mk_end) begin
        if (frame_is_open && esc_pending) begin
          keep_byte(b);
        end else if (frame_is_open) begin
          keep_byte(b);
          r.status.frame_done = 1'b1;
          r.status.frame_length = wr_ptr[LEN_W-1:0];
          wr_ptr = 0;
          frame_is_open = 1'b0;
          frames_closed++;
          if (ovf_seen) overflow_frames++;
        end
      end else if (frame_is_open) begin
        keep_byte(b);
      end
      esc_pending = (b == mk_escape) && !esc_pending;
    end
    r.status.frame_overflow = ovf_seen;
    r.status.in_frame = frame_is_open;
    return r;
  endfunction

  // Presents one item, with an occasional idle burst first, and records its expectation
  // once the transaction has completed.
  task automatic send_item(input logic func, input logic [BYTE_W-1:0] b,
                           input logic [READ_IDX_W-1:0] idx, input bit typed,
                           input efr_result_t typed_exp);
    efr_result_t pred;
    int gap;
    if (in_idle_pct != 0 && $urandom_range(0, 99) < in_idle_pct) begin
      gap = $urandom_range(1, 8);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.func <= func;
    in_ch.byte_in <= b;
    in_ch.read_index <= idx;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pred = predict_item(func, b, idx);
    expected_results.push_back(typed ? typed_exp : pred);
    items_sent++;
    phase_items++;
  endtask

  task automatic send_byte(input logic [BYTE_W-1:0] b);
    send_item(FUNC_BYTE, b, READ_IDX_W'($urandom), 1'b0, '0);
  endtask

  // Only positions written since reset are read back.
  task automatic send_read();
    logic [READ_IDX_W-1:0] idx;
    do idx = READ_IDX_W'($urandom_range(0, DEPTH - 1)); while (!written[idx]);
    send_item(FUNC_READ, BYTE_W'($urandom), idx, 1'b0, '0);
  endtask

  function automatic logic [BYTE_W-1:0] pick_byte();
    case ($urandom_range(0, 11))
      0: return mk_start;
      1: return mk_end;
      2: return mk_escape;
      default: return BYTE_W'($urandom);
    endcase
  endfunction

  // A frame of n payload bytes with markers escaped; now and then the end is left off.
  task automatic push_frame(input int n);
    logic [BYTE_W-1:0] b;
    int k;
    send_byte(mk_start);
    for (k = 0; k < n; k++) begin
      if ($urandom_range(0, 9) == 0) send_read();
      b = pick_byte();
      if (b == mk_start || b == mk_end || b == mk_escape) send_byte(mk_escape);
      send_byte(b);
    end
    if ($urandom_range(0, 9) != 0) send_byte(mk_end);
  endtask

  task automatic load_markers(input logic [BYTE_W-1:0] s, input logic [BYTE_W-1:0] e,
                              input logic [BYTE_W-1:0] x);
    logic [CFG_IDX_W-1:0] idx [4];
    logic [BYTE_W-1:0]    val [4];
    int k;
    idx = '{CFG_START, CFG_END, CFG_ESCAPE, CFG_UNUSED};
    val = '{s, e, x, BYTE_W'($urandom)};
    for (k = 0; k < 4; k++) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= idx[k];
      cfg_ch.data <= val[k];
      @(posedge clk);
      while (!cfg_ch.ready) @(posedge clk);
      set_marker(idx[k], val[k]);
    end
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic void note_mismatch(string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("MISMATCH: %s", msg);
  endfunction

  // Result side: drops ready in random stall bursts.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (stall_left != 0) begin
      out_ch.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (out_stall_pct != 0 && $urandom_range(0, 99) < out_stall_pct) begin
      out_ch.ready <= 1'b0;
      stall_left <= $urandom_range(0, 7);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    efr_result_t want;
    efr_result_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.status.frame_done = out_ch.frame_done;
      got.status.frame_length = out_ch.frame_length;
      got.status.frame_overflow = out_ch.frame_overflow;
      got.status.in_frame = out_ch.in_frame;
      got.read_data = out_ch.read_data;
      if (expected_results.size() == 0) begin
        note_mismatch($sformatf("result %0d arrived with nothing expected", results_seen));
      end else begin
        want = expected_results.pop_front();
        if (got.status.frame_done !== want.status.frame_done ||
            got.status.frame_length !== want.status.frame_length ||
            got.status.frame_overflow !== want.status.frame_overflow ||
            got.status.in_frame !== want.status.in_frame ||
            got.read_data !== want.read_data) begin
          note_mismatch({
            $sformatf("result %0d: expected done=%0d len=%0d ovf=%0d in_frame=%0d rd=%02h, ",
                      results_seen, want.status.frame_done, want.status.frame_length,
                      want.status.frame_overflow, want.status.in_frame, want.read_data),
            $sformatf("got done=%0d len=%0d ovf=%0d in_frame=%0d rd=%02h",
                      got.status.frame_done, got.status.frame_length,
                      got.status.frame_overflow, got.status.in_frame, got.read_data)});
        end
      end
      results_seen++;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding", cycle_count,
               expected_results.size());
      $display("escaped_frame_receiver test failed");
      $finish;
    end
  end

  // Directed rows under the reset markers. Expectations are typed in where obvious.
  stim_row_t dir_rows [23];

  logic [3*BYTE_W-1:0] phase_marks [NUM_PHASES];
  int in_idle_tab [NUM_PHASES];
  int out_stall_tab [NUM_PHASES];

  initial begin
    efr_result_t typed_exp;
    stim_row_t row;
    int p;
    int k;

    in_ch.valid <= 1'b0;
    in_ch.func <= FUNC_BYTE;
    in_ch.byte_in <= '0;
    in_ch.read_index <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= CFG_START;
    cfg_ch.data <= '0;

    dir_rows = '{
      '{FUNC_BYTE, 8'h00,      7'd0, 1'b1, 1'b0, 8'd0,  1'b0, 1'b0, 8'h00},
      '{FUNC_BYTE, 8'hFF,      7'd0, 1'b1, 1'b0, 8'd0,  1'b0, 1'b0, 8'h00},
      '{FUNC_BYTE, END_RST,    7'd0, 1'b1, 1'b0, 8'd0,  1'b0, 1'b0, 8'h00},
      '{FUNC_BYTE, ESCAPE_RST, 7'd0, 1'b1, 1'b0, 8'd0,  1'b0, 1'b0, 8'h00},
      // An escape pending outside a frame does not stop the start.
      '{FUNC_BYTE, START_RST,  7'd0, 1'b1, 1'b0, 8'd0,  1'b0, 1'b1, 8'h00},
      '{FUNC_BYTE, 8'h00,      7'd0, 1'b0, 1'b0, 8'd0,  1'b0, 1'b0, 8'h00},
      '{FUNC_BYTE, 8'hFF,      7'd0, 1'b0, 1'b0, 8'd0,  1'b0, 1'b0, 8'h00},
      '{FUNC_BYTE, ESCAPE_RST, 7'd0, 1'b0, 1'b0, 8'd0,  1'b0, 1'b0, 8'h00},
      '{FUNC_BYTE, START_RST,  7'd0, 1'b0, 1'b0, 8'd0,  1'b0, 1'b0, 8'h00},
      '{FUNC_BYTE, ESCAPE_RST, 7'd0, 1'b0, 1'b0, 8'd0,  1'b0, 1'b0, 8'h00},
      '{FUNC_BYTE, END_RST,    7'd0, 1'b0, 1'b0, 8'd0,  1'b0, 1'b0, 8'h00},
      '{FUNC_BYTE, ESCAPE_RST, 7'd0, 1'b0, 1'b0, 8'd0,  1'b0, 1'b0, 8'h00},
      // A second escape cancels the first, so the end marker closes the frame.
      '{FUNC_BYTE, ESCAPE_RST, 7'd0, 1'b0, 1'b0, 8'd0,  1'b0, 1'b0, 8'h00},
      '{FUNC_BYTE, END_RST,    7'd0, 1'b1, 1'b1, 8'd10, 1'b0, 1'b0, 8'h00},
      '{FUNC_READ, 8'hA5,      7'd0, 1'b1, 1'b0, 8'd0,  1'b0, 1'b0, START_RST},
      '{FUNC_READ, 8'h5A,      7'd9, 1'b1, 1'b0, 8'd0,  1'b0, 1'b0, END_RST},
      '{FUNC_BYTE, START_RST,  7'd0, 1'b0, 1'b0, 8'd0,  1'b0, 1'b0, 8'h00},
      // An unescaped start inside a frame restarts it.
      '{FUNC_BYTE, START_RST,  7'd0, 1'b0, 1'b0, 8'd0,  1'b0, 1'b0, 8'h00},
      '{FUNC_BYTE, ESCAPE_RST, 7'd0, 1'b0, 1'b0, 8'd0,  1'b0, 1'b0, 8'h00},
      '{FUNC_BYTE, START_RST,  7'd0, 1'b0, 1'b0, 8'd0,  1'b0, 1'b0, 8'h00},
      '{FUNC_BYTE, END_RST,    7'd0, 1'b1, 1'b1, 8'd4,  1'b0, 1'b0, 8'h00},
      '{FUNC_READ, 8'h00,      7'd2, 1'b0, 1'b0, 8'd0,  1'b0, 1'b0, 8'h00},
      '{FUNC_READ, 8'hFF,      7'd7, 1'b0, 1'b0, 8'd0,  1'b0, 1'b0, 8'h00}
    };

    phase_marks = '{
      {START_RST, END_RST, ESCAPE_RST},
      {8'h00, 8'hFF, 8'h80},
      {8'hFF, 8'h00, 8'h01},
      {8'h55, 8'h55, 8'hAA},
      {8'h10, 8'h20, 8'h20},
      {8'h30, 8'h40, 8'h30},
      {8'h99, 8'h99, 8'h99},
      {8'h7E, 8'h7D, 8'h7C}
    };
    in_idle_tab   = '{25, 10, 0, 40, 15, 30, 20, 0};
    out_stall_tab = '{25, 30, 0, 10, 40, 15, 20, 0};

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    in_idle_pct = 20;
    out_stall_pct = 20;
    for (k = 0; k < $size(dir_rows); k++) begin
      row = dir_rows[k];
      typed_exp.status.frame_done = row.done;
      typed_exp.status.frame_length = row.len;
      typed_exp.status.frame_overflow = row.ovf;
      typed_exp.status.in_frame = row.inf;
      typed_exp.read_data = row.rdata;
      send_item(row.func, row.byte_v, row.idx, row.typed, typed_exp);
    end

    for (p = 0; p < NUM_PHASES; p++) begin
      in_ch.valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clk);
      load_markers(phase_marks[p][23:16], phase_marks[p][15:8], phase_marks[p][7:0]);
      in_idle_pct = in_idle_tab[p];
      out_stall_pct = out_stall_tab[p];
      phase_items = 0;
      // One frame long enough to fill every position and overflow.
      if (p == 0) push_frame(130);
      while (phase_items < PHASE_ITEMS) begin
        k = $urandom_range(0, 99);
        if (k < 65) begin
          push_frame(($urandom_range(0, 14) == 0) ? $urandom_range(120, 140)
                                                   : $urandom_range(0, 20));
        end else if (k < 80 && written != '0) begin
          send_read();
        end else begin
          send_byte(pick_byte());
        end
      end
    end
    in_ch.valid <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Covered %0d items under %0d marker settings: ", items_sent, NUM_PHASES,
             "%0d frames closed, %0d of them overflowed, %0d reads.",
             frames_closed, overflow_frames, reads_done);
    $display("Checked %0d results, %0d mismatches.", results_seen, mismatches);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("escaped_frame_receiver test passed");
    end else begin
      $display("escaped_frame_receiver test failed");
    end
    $finish;
  end

endmodule
